// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge out of reset
`define HTHQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// condition that must never hold out of reset
`define HTHQ_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// File: rtl/hthq_pkg.sv
// constants, types and helpers for the heightmap height query core
// no dependencies
package hthq_pkg;

	localparam int GRID   = 256;
	localparam int ADDR_W = 16;
	localparam int DIV_W  = 48;
	localparam int DEN_W  = 26;
	localparam int MUL_W  = 26;

	localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Z      = 3'd1;
	localparam logic [2:0] CFG_TILE_SIZE     = 3'd2;
	localparam logic [2:0] CFG_GRID_POINTS   = 3'd3;
	localparam logic [2:0] CFG_MAX_HEIGHT    = 3'd4;
	localparam logic [2:0] CFG_MAX_PIXEL_SUM = 3'd5;

	localparam logic [0:0] MODE_LOAD  = 1'b0;
	localparam logic [0:0] MODE_QUERY = 1'b1;

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_LMUL = 18'h00002,
		S_LDIV = 18'h00004,
		S_LPTR = 18'h00008,
		S_LWR  = 18'h00010,
		S_QMX  = 18'h00020,
		S_QCX  = 18'h00040,
		S_QMZ  = 18'h00080,
		S_QCZ  = 18'h00100,
		S_RD0  = 18'h00200,
		S_RD1  = 18'h00400,
		S_RD2  = 18'h00800,
		S_RD3  = 18'h01000,
		S_ACC  = 18'h02000,
		S_QDIV = 18'h04000,
		S_QFIN = 18'h08000,
		S_DIV  = 18'h10000,
		S_OUT  = 18'h20000
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [DIV_W-1:0] v);
		logic signed [15:0] r;
		if (v > $signed(48'sd32767))
			r = 16'sh7fff;
		else if (v < -$signed(48'sd32768))
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// File: rtl/hthq_in_if.sv
// input channel of the height query core: load pixels and query points
// depends on nothing
interface hthq_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;

	modport source (output valid, mode, red, green, blue, pos_x, pos_z, input ready);
	modport sink   (input valid, mode, red, green, blue, pos_x, pos_z, output ready);
endinterface

// File: rtl/hthq_out_if.sv
// output channel of the height query core: one height word per input word
// depends on nothing
interface hthq_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] height;
	logic               out_of_range;

	modport source (output valid, height, out_of_range, input ready);
	modport sink   (input valid, height, out_of_range, output ready);
endinterface

// File: rtl/heightmap_triangle_height_query_core.sv
// heightmap height query core: height store, shared multiplier and divider, sequencer
// depends on hthq_pkg, hthq_in_if, hthq_out_if
//
// One word at a time. A load word turns a pixel into a Q8.8 height and writes it to the
// 64k-entry store in raster order; a query word finds the grid cell under a Q24.8 point
// and interpolates over one of its two triangles. Every word gives one result word.
// Timing is set by one restoring divider and one 26x26 multiplier:
// a load does a height divide, then a row/column divide of the pointer; a query does
// two cell divides, three store reads and a final rounding divide; a point outside the
// tile goes straight to its result. in_ch.ready is high only while the core is idle and
// no result is waiting. Store entries never loaded read back as arbitrary values.
module heightmap_triangle_height_query_core (
	input  logic        clk,
	input  logic        arst_n,
	hthq_in_if.sink     in_ch,
	hthq_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import hthq_pkg::*;

	state_t state_q, ret_q;

	logic signed [31:0] origin_x_q, origin_z_q;
	logic [15:0]        tile_size_q;
	logic [8:0]         grid_points_q;
	logic [14:0]        max_height_q;
	logic [9:0]         max_pixel_sum_q;

	logic [ADDR_W-1:0]  ptr_q;
	logic signed [15:0] h_q;
	logic               oor_q;
	logic [23:0]        tz_q, rx_q, rz_q;
	logic [7:0]         gx_q, gz_q;
	logic signed [MUL_W-1:0]   opa_q, opb_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [DIV_W-1:0]   acc_q;

	logic [DIV_W-1:0] div_num_q;
	logic [DEN_W-1:0] div_den_q, div_rem_q;
	logic [5:0]       div_cnt_q;
	logic             div_neg_q;

	logic [15:0] mem_q [0:GRID*GRID-1];
	logic [15:0] rdata_q;
	logic [ADDR_W-1:0] rd_addr;

	// effective configuration
	logic [8:0]  n_use;
	logic [7:0]  nm1;
	logic [16:0] nn;
	logic [15:0] ts_eff;
	logic [23:0] d;
	logic [9:0]  mps_eff;

	always_comb begin
		if (grid_points_q < 9'd2)
			n_use = 9'd2;
		else if (grid_points_q > 9'(GRID))
			n_use = 9'(GRID);
		else
			n_use = grid_points_q;
		nm1     = 8'(n_use - 9'd1);
		nn      = 17'(n_use * n_use);
		ts_eff  = (tile_size_q == 16'd0) ? 16'd1 : tile_size_q;
		d       = {ts_eff, 8'd0};
		mps_eff = (max_pixel_sum_q == 10'd0) ? 10'd1 : max_pixel_sum_q;
	end

	// query offsets and range test
	logic signed [32:0] dx, dz, d33;
	logic               oor;
	always_comb begin
		dx  = $signed({in_ch.pos_x[31], in_ch.pos_x}) - $signed({origin_x_q[31], origin_x_q});
		dz  = $signed({in_ch.pos_z[31], in_ch.pos_z}) - $signed({origin_z_q[31], origin_z_q});
		d33 = $signed({9'd0, d});
		oor = dx[32] || dz[32] || (dx > d33) || (dz > d33);
	end

	// pixel sum term
	logic [9:0]         psum;
	logic signed [11:0] lnum;
	always_comb begin
		psum = 10'(in_ch.red) + 10'(in_ch.green) + 10'(in_ch.blue);
		lnum = $signed({1'b0, psum, 1'b0}) - $signed({2'b00, mps_eff});
	end

	// triangle weights
	logic [24:0] sumr, d25, w0, w1, w2;
	logic        lower;
	always_comb begin
		d25   = {1'b0, d};
		sumr  = 25'(rx_q) + 25'(rz_q);
		lower = sumr < d25;
		w0    = lower ? d25 - sumr : sumr - d25;
		w1    = lower ? {1'b0, rx_q} : d25 - {1'b0, rz_q};
		w2    = lower ? {1'b0, rz_q} : d25 - {1'b0, rx_q};
	end

	logic rd_phase;
	always_comb begin
		rd_phase = state_q inside {S_RD1, S_RD2, S_RD3};
		case (state_q)
			S_RD0:   rd_addr = lower ? {gz_q, gx_q} : {8'(gz_q + 8'd1), 8'(gx_q + 8'd1)};
			S_RD1:   rd_addr = {gz_q, 8'(gx_q + 8'd1)};
			S_RD2:   rd_addr = {8'(gz_q + 8'd1), gx_q};
			default: rd_addr = {gz_q, gx_q};
		endcase
	end

	// shared multiplier
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	always_comb begin
		mul_a = rd_phase ? MUL_W'($signed(rdata_q)) : opa_q;
		case (state_q)
			S_RD1:   mul_b = $signed({1'b0, w0});
			S_RD2:   mul_b = $signed({1'b0, w1});
			S_RD3:   mul_b = $signed({1'b0, w2});
			default: mul_b = opb_q;
		endcase
		mul_p = mul_a * mul_b;
	end

	// divider step and signed quotient fix-up
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DIV_W-1:0] qup, qs;
	always_comb begin
		trial = {div_rem_q, div_num_q[DIV_W-1]};
		ge    = trial >= {1'b0, div_den_q};
		qup   = div_num_q + DIV_W'(|div_rem_q);
		qs    = div_neg_q ? DIV_W'(-qup) : div_num_q;
	end

	// signed numerators for the rounding divides
	logic signed [DIV_W-1:0] lda, qda;
	always_comb begin
		lda = $signed({prod_q[DIV_W-2:0], 1'b0}) + $signed(DIV_W'(mps_eff));
		qda = $signed({acc_q[DIV_W-2:0], 1'b0}) + $signed(DIV_W'(d));
	end

	// cell index with far edge clamp
	logic [7:0]  cg;
	logic [23:0] cr;
	always_comb begin
		if (div_num_q >= DIV_W'(nm1)) begin
			cg = 8'(nm1 - 8'd1);
			cr = d;
		end else begin
			cg = div_num_q[7:0];
			cr = div_rem_q[23:0];
		end
	end

	logic [16:0] ptr_next;
	assign ptr_next = 17'(ptr_q) + 17'd1;

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = (state_q == S_OUT);
	assign out_ch.height       = h_q;
	assign out_ch.out_of_range = oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= '0;
			origin_z_q      <= '0;
			tile_size_q     <= 16'd800;
			grid_points_q   <= 9'd256;
			max_height_q    <= 15'd10240;
			max_pixel_sum_q <= 10'd765;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X:      origin_x_q      <= cfg_wdata;
				CFG_ORIGIN_Z:      origin_z_q      <= cfg_wdata;
				CFG_TILE_SIZE:     tile_size_q     <= cfg_wdata[15:0];
				CFG_GRID_POINTS:   grid_points_q   <= cfg_wdata[8:0];
				CFG_MAX_HEIGHT:    max_height_q    <= cfg_wdata[14:0];
				CFG_MAX_PIXEL_SUM: max_pixel_sum_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.mode == MODE_LOAD) begin
							if (17'(ptr_q) >= nn)
								ptr_q <= '0;
							state_q <= S_LMUL;
						end else if (oor) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_QMX;
						end
					end
				end
				S_LMUL: state_q <= S_LDIV;
				S_LDIV: begin
					ret_q   <= S_LPTR;
					state_q <= S_DIV;
				end
				S_LPTR: begin
					ret_q   <= S_LWR;
					state_q <= S_DIV;
				end
				S_LWR: begin
					ptr_q   <= (ptr_next >= nn) ? '0 : ptr_next[ADDR_W-1:0];
					state_q <= S_OUT;
				end
				S_QMX: begin
					ret_q   <= S_QCX;
					state_q <= S_DIV;
				end
				S_QCX: state_q <= S_QMZ;
				S_QMZ: begin
					ret_q   <= S_QCZ;
					state_q <= S_DIV;
				end
				S_QCZ: state_q <= S_RD0;
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_ACC;
				S_ACC: state_q <= S_QDIV;
				S_QDIV: begin
					ret_q   <= S_QFIN;
					state_q <= S_DIV;
				end
				S_QFIN: state_q <= S_OUT;
				S_DIV: begin
					if (div_cnt_q == 6'(DIV_W - 1))
						state_q <= ret_q;
				end
				S_OUT: begin
					if (out_ch.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_ch.mode == MODE_LOAD) begin
					opa_q <= MUL_W'(lnum);
					opb_q <= $signed({11'd0, max_height_q});
				end else begin
					h_q   <= sat16(DIV_W'(max_height_q) + DIV_W'(1));
					oor_q <= 1'b1;
					tz_q  <= dz[23:0];
					opa_q <= $signed({2'b00, dx[23:0]});
					opb_q <= $signed({18'd0, nm1});
				end
			end
			S_LMUL: prod_q <= mul_p;
			S_LDIV: begin
				div_neg_q <= lda[DIV_W-1];
				div_num_q <= lda[DIV_W-1] ? DIV_W'(-lda) : lda;
				div_den_q <= {15'd0, mps_eff, 1'b0};
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			S_LPTR: begin
				h_q       <= sat16(qs);
				div_neg_q <= 1'b0;
				div_num_q <= DIV_W'(ptr_q);
				div_den_q <= DEN_W'(n_use);
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			S_LWR: oor_q <= 1'b0;
			S_QMX, S_QMZ: begin
				div_neg_q <= 1'b0;
				div_num_q <= mul_p[DIV_W-1:0];
				div_den_q <= DEN_W'(d);
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			S_QCX: begin
				gx_q  <= cg;
				rx_q  <= cr;
				opa_q <= $signed({2'b00, tz_q});
			end
			S_QCZ: begin
				gz_q <= cg;
				rz_q <= cr;
			end
			S_RD0: acc_q <= '0;
			S_RD1: prod_q <= mul_p;
			S_RD2, S_RD3: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + prod_q[DIV_W-1:0];
			end
			S_ACC: acc_q <= acc_q + prod_q[DIV_W-1:0];
			S_QDIV: begin
				div_neg_q <= qda[DIV_W-1];
				div_num_q <= qda[DIV_W-1] ? DIV_W'(-qda) : qda;
				div_den_q <= {1'b0, d, 1'b0};
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			S_QFIN: begin
				h_q   <= sat16(qs);
				oor_q <= 1'b0;
			end
			S_DIV: begin
				// one quotient bit a cycle, quotient shifts into the numerator register
				div_rem_q <= ge ? DEN_W'(trial - {1'b0, div_den_q}) : trial[DEN_W-1:0];
				div_num_q <= {div_num_q[DIV_W-2:0], ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	// height store
	always_ff @(posedge clk) begin
		if (state_q == S_LWR)
			mem_q[{div_num_q[7:0], div_rem_q[7:0]}] <= h_q;
		rdata_q <= mem_q[rd_addr];
	end

endmodule

// File: rtl/hthq_checker.sv
// port-level checks for the heightmap height query core, bound to the top level
// depends on assert_macros.svh and heightmap_triangle_height_query_core
`include "assert_macros.svh"
module hthq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_height,
	input logic               out_oor
);
	// a waiting result holds until taken
	`HTHQ_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_height))
	// one word in flight: never ready while a result waits
	`HTHQ_NEVER(a_one_in_flight, clk, arst_n, in_ready && out_valid)
	// an accepted word closes the input until its result is taken
	`HTHQ_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	// outside-tile answer is max height plus one, saturated, always positive
	`HTHQ_ASSERT(a_oor_positive, clk, arst_n, out_valid && out_oor |-> out_height > 16'sd0)
endmodule

bind heightmap_triangle_height_query_core hthq_checker u_hthq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_height (out_ch.height),
	.out_oor    (out_ch.out_of_range)
);

// File: dv/heightmap_triangle_height_query_core_tb.sv
// testbench for the heightmap height query core: pixel loads and triangle height queries
// depends on hthq_pkg, hthq_in_if, hthq_out_if and heightmap_triangle_height_query_core
`timescale 1ns / 100ps

module heightmap_triangle_height_query_core_tb;
	import hthq_pkg::*;

	localparam int LIMIT = 500000;
	localparam int STORE = GRID * GRID;

	typedef struct {
		logic               mode;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
	} word_t;

	typedef struct {
		logic signed [15:0] height;
		logic               out_of_range;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_ORIGIN_X;
	logic [31:0] cfg_wdata = '0;

	hthq_in_if  in_ch();
	hthq_out_if out_ch();

	heightmap_triangle_height_query_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// register copies
	logic signed [31:0] org_x = 0, org_z = 0;
	logic [15:0] tile = 16'd800;
	logic [8:0]  gpts = 9'd256;
	logic [14:0] maxh = 15'd10240;
	logic [9:0]  mps = 10'd765;

	// predicted store and the generator's view of which entries are loaded
	logic signed [15:0] height_mem [STORE];
	bit  loaded_plan [STORE];
	int  load_ptr = 0, plan_ptr = 0;

	word_t   pending[$];
	answer_t heights_due[$];
	int      errors = 0;
	int      cycles = 0;
	bit      no_idle = 0;
	bit      held = 0;
	int      gap = 0, stall = 0;

	function automatic int grid_n();
		int n;
		n = gpts;
		if (n < 2) n = 2;
		if (n > 256) n = 256;
		return n;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint a, b, q;
		a = 2 * num + den;
		b = 2 * den;
		q = a / b;
		if ((a % b) != 0 && a < 0) q -= 1;
		return q;
	endfunction

	function automatic logic signed [15:0] sat_q88(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// raster slot of the next pixel, advancing the pointer
	function automatic int next_slot(ref int ptr);
		int n, slot;
		n = grid_n();
		if (ptr >= n * n) ptr = 0;
		slot = (ptr / n) * GRID + (ptr % n);
		ptr = (ptr + 1 >= n * n) ? 0 : ptr + 1;
		return slot;
	endfunction

	function automatic void cell_of(longint t, longint n, longint d,
			output longint g, output longint r);
		longint num;
		num = t * (n - 1);
		g = num / d;
		r = num % d;
		if (g >= n - 1) begin
			g = n - 2;
			r = d;
		end
	endfunction

	// finds the triangle under a point; returns 1 when the point is off the tile
	function automatic bit locate(logic signed [31:0] px, logic signed [31:0] pz,
			output longint d, output longint rx, output longint rz,
			output int a00, output int a10, output int a01, output int a11,
			output bit upper);
		longint tx, tz, gx, gz, n;
		n = grid_n();
		d = longint'(tile == 0 ? 16'd1 : tile) * 256;
		tx = longint'(px) - longint'(org_x);
		tz = longint'(pz) - longint'(org_z);
		rx = 0; rz = 0; a00 = 0; a10 = 0; a01 = 0; a11 = 0; upper = 0;
		if (tx < 0 || tz < 0 || tx > d || tz > d) return 1;
		cell_of(tx, n, d, gx, rx);
		cell_of(tz, n, d, gz, rz);
		a00 = int'((gz * GRID + gx) % STORE);
		a10 = int'((gz * GRID + gx + 1) % STORE);
		a01 = int'(((gz + 1) * GRID + gx) % STORE);
		a11 = int'(((gz + 1) * GRID + gx + 1) % STORE);
		upper = (rx + rz >= d);
		return 0;
	endfunction

	task automatic height_for(input word_t w, output answer_t r);
		longint sum, div, h, d, rx, rz, num;
		int a00, a10, a01, a11;
		bit upper;
		r.out_of_range = 1'b0;
		if (w.mode == MODE_LOAD) begin
			sum = longint'(w.red) + longint'(w.green) + longint'(w.blue);
			div = (mps == 0) ? 1 : longint'(mps);
			r.height = sat_q88(round_div((2 * sum - div) * longint'(maxh), div));
			height_mem[next_slot(load_ptr)] = r.height;
		end else if (locate(w.pos_x, w.pos_z, d, rx, rz, a00, a10, a01, a11, upper)) begin
			r.height = sat_q88(longint'(maxh) + 1);
			r.out_of_range = 1'b1;
		end else begin
			if (!upper)
				num = height_mem[a00] * (d - rx - rz) + height_mem[a10] * rx
					+ height_mem[a01] * rz;
			else
				num = height_mem[a10] * (d - rz) + height_mem[a11] * (rx + rz - d)
					+ height_mem[a01] * (d - rx);
			r.height = sat_q88(round_div(num, d));
		end
	endtask

	// stimulus helpers
	task automatic add_load(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		word_t w;
		w = '{mode: MODE_LOAD, red: r, green: g, blue: b, pos_x: $urandom, pos_z: $urandom};
		loaded_plan[next_slot(plan_ptr)] = 1;
		pending = {pending, w};
	endtask

	// queries that would read a never-loaded entry are dropped
	task automatic add_query(input logic signed [31:0] px, input logic signed [31:0] pz);
		word_t w;
		longint d, rx, rz;
		int a00, a10, a01, a11;
		bit upper;
		if (!locate(px, pz, d, rx, rz, a00, a10, a01, a11, upper)) begin
			if (!loaded_plan[a00] || !loaded_plan[a10] || !loaded_plan[a01]) return;
			if (upper && !loaded_plan[a11]) return;
		end
		w = '{mode: MODE_QUERY, red: $urandom, green: $urandom, blue: $urandom,
			pos_x: px, pos_z: pz};
		pending = {pending, w};
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || heights_due.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ORIGIN_X:      org_x = val;
			CFG_ORIGIN_Z:      org_z = val;
			CFG_TILE_SIZE:     tile = val[15:0];
			CFG_GRID_POINTS:   gpts = val[8:0];
			CFG_MAX_HEIGHT:    maxh = val[14:0];
			CFG_MAX_PIXEL_SUM: mps = val[9:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] tile_span();
		return (tile == 0 ? 32'd1 : 32'(tile)) * 256;
	endfunction

	task automatic random_query();
		logic [31:0] t_x, t_z, d;
		int pick;
		d = tile_span();
		pick = $urandom_range(0, 9);
		t_x = $urandom_range(0, d);
		t_z = $urandom_range(0, d);
		if (pick == 0) begin
			add_query($urandom, $urandom);
		end else if (pick == 1) begin
			add_query(org_x - $urandom_range(1, 300), org_z + t_z);
		end else if (pick == 2) begin
			add_query(org_x + t_x, org_z + d + $urandom_range(1, 300));
		end else if (pick == 3) begin
			add_query(org_x + ($urandom_range(0, 1) ? d : 0),
				org_z + ($urandom_range(0, 1) ? d : 0));
		end else begin
			add_query(org_x + t_x, org_z + t_z);
		end
	endtask

	task automatic random_phase(input int count);
		int n, pick;
		set_reg(CFG_ORIGIN_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
		set_reg(CFG_ORIGIN_Z, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
		pick = $urandom_range(0, 3);
		set_reg(CFG_TILE_SIZE, pick == 0 ? 1 : pick == 1 ? 65535 : $urandom_range(1, 4000));
		set_reg(CFG_GRID_POINTS, $urandom_range(0, 6));
		set_reg(CFG_MAX_HEIGHT, $urandom_range(1, 32767));
		set_reg(CFG_MAX_PIXEL_SUM, $urandom_range(0, 765));
		n = grid_n();
		for (int i = 0; i < n * n; i++) add_load($urandom, $urandom, $urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 3) add_load($urandom, $urandom, $urandom);
			else random_query();
		end
	endtask

	// driver
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			height_for(pending[0], a);
			heights_due = {heights_due, a};
			void'(pending.pop_front());
			held = 0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!held) begin
			if (gap > 0) begin
				gap--;
				in_ch.valid <= 1'b0;
			end else if (pending.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(0, 2);
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.mode <= pending[0].mode;
				in_ch.red <= pending[0].red;
				in_ch.green <= pending[0].green;
				in_ch.blue <= pending[0].blue;
				in_ch.pos_x <= pending[0].pos_x;
				in_ch.pos_z <= pending[0].pos_z;
				in_ch.valid <= 1'b1;
				held = 1;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			out_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			stall = $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (heights_due.size() == 0) begin
				$display("%0t: unexpected word: height %0d flag %0b", $time,
					out_ch.height, out_ch.out_of_range);
				errors++;
			end else begin
				e = heights_due.pop_front();
				if (out_ch.height !== e.height) begin
					$display("%0t: height expected %0d actual %0d", $time,
						e.height, out_ch.height);
					errors++;
				end
				if (out_ch.out_of_range !== e.out_of_range) begin
					$display("%0t: out_of_range expected %0b actual %0b", $time,
						e.out_of_range, out_ch.out_of_range);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [31:0] d;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_LOAD;
		in_ch.red = '0;
		in_ch.green = '0;
		in_ch.blue = '0;
		in_ch.pos_x = '0;
		in_ch.pos_z = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// smallest tile and grid, full-scale heights, origins at the edges of the range
		set_reg(CFG_ORIGIN_X, 32'h8000_0000);
		set_reg(CFG_ORIGIN_Z, 32'h7fff_ff00);
		set_reg(CFG_TILE_SIZE, 1);
		set_reg(CFG_GRID_POINTS, 2);
		set_reg(CFG_MAX_HEIGHT, 32767);
		set_reg(CFG_MAX_PIXEL_SUM, 1);
		add_load(8'd0, 8'd0, 8'd0);
		add_load(8'd255, 8'd255, 8'd255);
		add_load(8'd255, 8'd0, 8'd0);
		add_load(8'd0, 8'd0, 8'd1);
		add_query(org_x, org_z);
		add_query(org_x + 256, org_z);
		add_query(org_x, org_z + 128);
		add_query(org_x + 128, org_z + 128);
		add_query(org_x + 200, org_z + 100);
		add_query(org_x + 256, org_z + 256);
		add_query(org_x - 1, org_z);
		add_query(org_x + 257, org_z);
		add_query(32'h7fff_ffff, 32'h8000_0000);
		add_query(32'h8000_0000, 32'h7fff_ffff);

		// zero registers, grid below two, load wrap
		set_reg(CFG_ORIGIN_X, 0);
		set_reg(CFG_ORIGIN_Z, 0);
		set_reg(CFG_TILE_SIZE, 0);
		set_reg(CFG_GRID_POINTS, 0);
		set_reg(CFG_MAX_HEIGHT, 1);
		set_reg(CFG_MAX_PIXEL_SUM, 0);
		for (int i = 0; i < 5; i++) add_load($urandom, $urandom, $urandom);
		add_query(100, 50);
		add_query(256, 256);

		// grid above the store size acts as the full grid; one row and a bit loaded
		set_reg(CFG_TILE_SIZE, 65535);
		set_reg(CFG_GRID_POINTS, 511);
		set_reg(CFG_MAX_HEIGHT, 10240);
		set_reg(CFG_MAX_PIXEL_SUM, 765);
		for (int i = 0; i < 280; i++) add_load($urandom, $urandom, $urandom);
		d = tile_span();
		for (int i = 0; i < 30; i++)
			add_query($urandom_range(0, d / 12), $urandom_range(0, d / 255));

		// grid lowered mid load: pointer restarts
		set_reg(CFG_GRID_POINTS, 3);
		for (int i = 0; i < 9; i++) add_load($urandom, $urandom, $urandom);
		for (int i = 0; i < 8; i++) random_query();

		for (int p = 0; p < 2; p++) random_phase(20);
		no_idle = 1;
		random_phase(30);

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
